// ===== hdl/lffb_pkg.sv =====
// Shared types, sizes and pixel arithmetic for the LED frame fade and blur block.
// No dependencies.
package lffb_pkg;

	localparam int MAX_COLS = 32;
	localparam int MAX_ROWS = 32;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int MAX_DIM  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
	localparam int LEN_W    = $clog2(MAX_DIM + 2);
	localparam int PIX_W    = 32;
	localparam int CFG_W    = 6;

	typedef logic [1:0] op_t;
	localparam op_t OP_WRITE = 2'd0;
	localparam op_t OP_READ  = 2'd1;
	localparam op_t OP_FADE  = 2'd2;
	localparam op_t OP_BLUR  = 2'd3;

	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [LEN_W-1:0]  len_t;

	// per channel (v * k) >> 8, k up to 256
	function automatic pix_t px_scale(input pix_t c, input logic [8:0] k);
		pix_t r;
		logic [16:0] m;
		r = '0;
		for (int i = 0; i < 4; i++) begin
			m = c[8*i +: 8] * k;
			r[8*i +: 8] = m[15:8];
		end
		return r;
	endfunction

	// per channel saturating add
	function automatic pix_t px_sat(input pix_t a, input pix_t b);
		pix_t r;
		logic [8:0] s;
		r = '0;
		for (int i = 0; i < 4; i++) begin
			s = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]};
			r[8*i +: 8] = s[8] ? 8'hFF : s[7:0];
		end
		return r;
	endfunction

	function automatic addr_t px_addr(input len_t r, input len_t c);
		return ADDR_W'(int'(r) * MAX_COLS + int'(c));
	endfunction

endpackage

// ===== hdl/lffb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lffb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/led_frame_fade_and_blur.sv =====
// A write raises done in the cycle after acceptance; a read passes the RAM read
//   register and S_READ before done. Fade sweeps every row; blur sweeps every row,
//   then every column, via the single RAM read port, one pixel a cycle in a line.
// One operation at a time: busy is high while a read or sweep is in flight.
// Reset: asynchronous; afterwards a clearing pass writes black into every pixel
//   with busy high. Sizes reset to 32x32. The receiver cannot stall done.
module led_frame_fade_and_blur (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  lffb_pkg::op_t         opcode,
	input  logic [4:0]            col,
	input  logic [4:0]            row,
	input  logic [7:0]            red_in,
	input  logic [7:0]            green_in,
	input  logic [7:0]            blue_in,
	input  logic [7:0]            white_in,
	input  logic [7:0]            amount,
	output logic                  done,
	output logic [7:0]            red_out,
	output logic [7:0]            green_out,
	output logic [7:0]            blue_out,
	output logic [7:0]            white_out,
	output logic                  bad_coordinate,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [lffb_pkg::CFG_W-1:0] cfg_data
);
	import lffb_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_READ  = 4'b0100,
		S_SWEEP = 4'b1000
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] cols_q, rows_q;
	addr_t clr_q;

	// sweep control: pass 0 walks rows, pass 1 walks columns
	logic pass_q, fade_q;
	len_t line_q, pos_q;
	logic [8:0] keep_q;
	logic [7:0] share_q;

	// stage after the RAM read
	logic  rdv_s1, first_s1;
	addr_t addr_s1;
	// blur carry state
	pix_t  nv_q, carry_q;
	addr_t prev_q;

	logic done_q, bad_q;
	pix_t out_q;

	// RAM ports
	logic  we;
	addr_t waddr, raddr;
	pix_t  wdata, rdata;

	lffb_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_frame (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// sizes in use, clamped to the store
	len_t nc, nr, len, lines;
	assign nc    = (int'(cols_q) > MAX_COLS) ? LEN_W'(MAX_COLS) : LEN_W'(cols_q);
	assign nr    = (int'(rows_q) > MAX_ROWS) ? LEN_W'(MAX_ROWS) : LEN_W'(rows_q);
	assign len   = pass_q ? nr : nc;
	assign lines = pass_q ? nc : nr;

	logic accept, in_bad, empty;
	assign accept = start && (state_q == S_IDLE);
	assign in_bad = (LEN_W'(col) >= nc) || (LEN_W'(row) >= nr);
	assign empty  = (nc == '0) || (nr == '0);

	logic issue, flush, line_end;
	assign issue    = (state_q == S_SWEEP) && (pos_q < len);
	assign line_end = (state_q == S_SWEEP) && (pos_q == len + len_t'(1));
	assign flush    = line_end && !fade_q;

	addr_t sweep_addr;
	assign sweep_addr = pass_q ? px_addr(pos_q, line_q) : px_addr(line_q, pos_q);

	// datapath on the pixel just read
	pix_t part, keepv, carry_in, nv_new;
	assign part     = px_scale(rdata, {1'b0, share_q});
	assign keepv    = px_scale(rdata, keep_q);
	assign carry_in = first_s1 ? '0 : carry_q;
	assign nv_new   = px_sat(keepv, carry_in);

	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = keepv;
		raddr = sweep_addr;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (accept) begin
			raddr = px_addr(LEN_W'(row), LEN_W'(col));
			waddr = px_addr(LEN_W'(row), LEN_W'(col));
			wdata = {white_in, blue_in, green_in, red_in};
			we    = (opcode == OP_WRITE) && !in_bad;
		end else if (rdv_s1 && fade_q) begin
			we = 1'b1;
		end else if (rdv_s1 && !first_s1) begin
			// previous pixel picks up the forward share of this one
			we    = 1'b1;
			waddr = prev_q;
			wdata = px_sat(nv_q, part);
		end else if (flush) begin
			// last pixel of the line has no successor
			we    = 1'b1;
			waddr = prev_q;
			wdata = nv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CFG_W'(32);
			rows_q <= CFG_W'(32);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLS: cols_q <= cfg_data;
				REG_ROWS: rows_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			pass_q   <= 1'b0;
			fade_q   <= 1'b0;
			line_q   <= '0;
			pos_q    <= '0;
			rdv_s1   <= 1'b0;
			first_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			rdv_s1 <= issue;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + addr_t'(1);
					if (clr_q == addr_t'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						pass_q <= 1'b0;
						line_q <= '0;
						pos_q  <= '0;
						fade_q <= (opcode == OP_FADE);
						case (opcode)
							OP_WRITE: done_q <= 1'b1;
							OP_READ: begin
								if (in_bad) done_q <= 1'b1;
								else        state_q <= S_READ;
							end
							default: begin
								if (empty) done_q <= 1'b1;
								else       state_q <= S_SWEEP;
							end
						endcase
					end
				end
				S_READ: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SWEEP: begin
					if (issue) first_s1 <= (pos_q == '0);
					if (line_end) begin
						pos_q <= '0;
						if (line_q == lines - len_t'(1)) begin
							line_q <= '0;
							if (!fade_q && !pass_q) begin
								pass_q <= 1'b1;
							end else begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end else begin
							line_q <= line_q + len_t'(1);
						end
					end else begin
						pos_q <= pos_q + len_t'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (issue) addr_s1 <= sweep_addr;
		if (rdv_s1) begin
			nv_q    <= nv_new;
			carry_q <= part;
			prev_q  <= addr_s1;
		end
		if (accept) begin
			keep_q  <= 9'd256 - {1'b0, amount};
			share_q <= {1'b0, amount[7:1]} + 8'd1;
			out_q   <= '0;
			bad_q   <= (opcode == OP_WRITE || opcode == OP_READ) && in_bad;
		end else if (state_q == S_READ) begin
			out_q <= rdata;
			bad_q <= 1'b0;
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign red_out        = out_q[7:0];
	assign green_out      = out_q[15:8];
	assign blue_out       = out_q[23:16];
	assign white_out      = out_q[31:24];
	assign bad_coordinate = bad_q;
endmodule

// ===== hdl/lffb_checker.sv =====
// Port-level checks for led_frame_fade_and_blur, attached by bind.
// Depends on lffb_pkg.
module lffb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] opcode,
	input logic       done,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out,
	input logic [7:0] white_out,
	input logic       bad_coordinate
);
	import lffb_pkg::*;

	// a write transfer completes in the next cycle with an all-zero pixel
	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_WRITE) |=> (done && red_out == 8'd0 &&
		green_out == 8'd0 && blue_out == 8'd0 && white_out == 8'd0))
		else $error("write transfer did not complete next cycle");

	// an accepted read either completes at once or holds busy
	a_read_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_READ) |=> (done || busy))
		else $error("read transfer lost");

	// a flagged coordinate never returns pixel data
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_coordinate) |-> (red_out == 8'd0 && green_out == 8'd0 &&
		blue_out == 8'd0 && white_out == 8'd0))
		else $error("bad coordinate with pixel data");

	// a read that went busy ends with done the cycle busy drops
	a_read_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_READ) ##1 busy |=> (done && !busy))
		else $error("read did not finish in two cycles");
endmodule

bind led_frame_fade_and_blur lffb_checker u_lffb_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
	.done(done), .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
	.white_out(white_out), .bad_coordinate(bad_coordinate)
);
